// File: rtl/arp_pkg.sv
// Shared types and constants for the ARP cache block.
// Holds the beat structs, the command passed from front to back, and status codes.
// Depends on nothing; every other file in rtl imports it.
package arp_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] MIN_PACKET_LEN = 16'd28;
    localparam logic [15:0] OPER_REQUEST = 16'd1;

    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ip_in;
        logic [47:0] mac_in;
        logic [15:0] oper;
        logic [31:0] target_ip;
        logic [15:0] packet_length;
        logic [5:0]  entry_index;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] mac_out;
        logic [31:0] ip_out;
        logic        send_reply;
    } out_beat_t;

    typedef enum logic [1:0] {
        OP_LEARN,
        OP_LOOKUP,
        OP_READ,
        OP_FIXED
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [5:0]  idx;
        logic        reply;
        logic [1:0]  status;
    } cmd_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } entry_t;

endpackage

// File: rtl/arp_front.sv
// Front end of the ARP cache: holds own_ip and turns each input beat into a command.
// Short packets and unused kinds are resolved here. Depends on arp_pkg.
module arp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  arp_pkg::in_beat_t in_data,
    input  logic              q_full,
    output logic              push,
    output arp_pkg::cmd_t     push_cmd
);
    import arp_pkg::*;

    logic [31:0] own_ip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else if (cfg_we)
        begin
            own_ip_reg <= cfg_data;
        end
    end

    assign in_stall = q_full;
    assign push = in_valid && !q_full;

    always_comb
    begin
        push_cmd = '{op: OP_FIXED, ip: '0, mac: '0, idx: '0, reply: 1'b0, status: ST_MISS};
        case (in_data.kind)
            KIND_PACKET:
            begin
                if (in_data.packet_length < MIN_PACKET_LEN)
                begin
                    push_cmd.status = ST_SHORT;
                end
                else
                begin
                    push_cmd.op = OP_LEARN;
                    push_cmd.ip = in_data.ip_in;
                    push_cmd.mac = in_data.mac_in;
                    push_cmd.status = ST_OK;
                    push_cmd.reply = (in_data.oper == OPER_REQUEST) &&
                                     (in_data.target_ip == own_ip_reg);
                end
            end
            KIND_LOOKUP:
            begin
                push_cmd.op = OP_LOOKUP;
                push_cmd.ip = in_data.ip_in;
            end
            KIND_READ:
            begin
                push_cmd.op = OP_READ;
                push_cmd.idx = in_data.entry_index;
            end
            default:
            begin
                push_cmd.op = OP_FIXED;
            end
        endcase
    end

endmodule

// File: rtl/arp_queue.sv
// Short command queue between the front end and the table engine of the ARP cache.
// Depth is set by QUEUE_DEPTH in arp_pkg.
module arp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  arp_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          head_valid,
    output arp_pkg::cmd_t head,
    input  logic          pop
);
    import arp_pkg::*;

    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/arp_back.sv
// Table engine of the ARP cache: entry memory, valid bits, sequential scan and write-back.
// Takes commands from arp_queue and drives the registered output beat. Depends on arp_pkg.
module arp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  arp_pkg::cmd_t      head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output arp_pkg::out_beat_t out_data
);
    import arp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_READ,
        S_DONE
    } state_t;

    entry_t            entry_mem [ENTRIES];
    entry_t            rd_entry_reg;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [CNT_W-1:0]  issue_reg;
    logic              rd_live_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [IDX_W-1:0]  slot_reg;
    out_beat_t         res_reg;
    out_beat_t         out_reg;
    logic              out_valid_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic              out_free;
    logic              issuing;
    logic              hit;
    logic              last;
    logic              read_ok;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_ra;

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign pop = (state_reg == S_IDLE) && head_valid;
    assign issuing = (state_reg == S_SCAN) && (issue_reg < CNT_W'(ENTRIES));
    assign hit = rd_live_reg && valid_reg[rd_idx_reg] && (rd_entry_reg.ip == cmd_reg.ip);
    assign last = rd_live_reg && (rd_idx_reg == IDX_W'(ENTRIES - 1));
    assign read_ok = (7'(head.idx) < 7'(ENTRIES)) && valid_reg[head.idx[IDX_W-1:0]];
    assign mem_we = (state_reg == S_WRITE);
    assign mem_ra = (state_reg == S_IDLE) ? head.idx[IDX_W-1:0] : issue_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[slot_reg] <= '{ip: cmd_reg.ip, mac: cmd_reg.mac};
        end
        rd_entry_reg <= entry_mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg <= '0;
            rd_live_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        cmd_reg <= head;
                        issue_reg <= '0;
                        free_found_reg <= 1'b0;
                        case (head.op)
                            OP_LEARN, OP_LOOKUP:
                            begin
                                state_reg <= S_SCAN;
                            end
                            OP_READ:
                            begin
                                if (read_ok)
                                begin
                                    state_reg <= S_READ;
                                end
                                else
                                begin
                                    res_reg <= '{status: ST_MISS, mac_out: '0, ip_out: '0,
                                                 send_reply: 1'b0};
                                    state_reg <= S_DONE;
                                end
                            end
                            default:
                            begin
                                res_reg <= '{status: head.status, mac_out: '0, ip_out: '0,
                                             send_reply: 1'b0};
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    rd_live_reg <= issuing && !hit;
                    if (issuing)
                    begin
                        rd_idx_reg <= issue_reg[IDX_W-1:0];
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (hit)
                    begin
                        if (cmd_reg.op == OP_LOOKUP)
                        begin
                            res_reg <= '{status: ST_OK, mac_out: rd_entry_reg.mac,
                                         ip_out: rd_entry_reg.ip, send_reply: 1'b0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            slot_reg <= rd_idx_reg;
                            state_reg <= S_WRITE;
                        end
                    end
                    else if (rd_live_reg)
                    begin
                        if (!valid_reg[rd_idx_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                        if (last)
                        begin
                            if (cmd_reg.op == OP_LOOKUP)
                            begin
                                res_reg <= '{status: ST_MISS, mac_out: '0, ip_out: '0,
                                             send_reply: 1'b0};
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                if (free_found_reg)
                                begin
                                    slot_reg <= free_idx_reg;
                                end
                                else if (!valid_reg[rd_idx_reg])
                                begin
                                    slot_reg <= rd_idx_reg;
                                end
                                else
                                begin
                                    slot_reg <= '0;
                                end
                                state_reg <= S_WRITE;
                            end
                        end
                    end
                end
                S_WRITE:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    res_reg <= '{status: ST_OK, mac_out: cmd_reg.mac, ip_out: cmd_reg.ip,
                                 send_reply: cmd_reg.reply};
                    state_reg <= S_DONE;
                end
                S_READ:
                begin
                    res_reg <= '{status: ST_OK, mac_out: rd_entry_reg.mac,
                                 ip_out: rd_entry_reg.ip, send_reply: 1'b0};
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/arp_cache_with_reply_decision_top.sv
// The ARP cache keeps ENTRIES IPv4-to-MAC pairs in a memory with one read and one write
// port and works on one beat at a time. A learn or lookup scans the memory one entry per
// clock and ends early on a hit. A learn passes the scan, write and done states before
// loading the output register, a lookup scan and done, a valid indexed read read and done;
// other beats go straight to done. An accepted beat is registered in the queue before the
// engine can take it. A two-deep command queue lets input beats be taken while the engine
// works, and a finished beat waits in the output register; while it is stalled the engine
// holds the next result, and the input stalls whenever the queue is full. The valid bits
// clear at reset; no clearing pass is needed.
// Top level; instantiates arp_front, arp_queue and arp_back, and depends on arp_pkg.
module arp_cache_with_reply_decision_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  arp_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output arp_pkg::out_beat_t out_data
);
    import arp_pkg::*;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic head_valid;
    cmd_t head;
    logic pop;

    arp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    arp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    arp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
